// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg)
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

// ----- rtl/core/tdbs_pkg.sv -----
`default_nettype none
package tdbs_pkg;

   localparam logic [2:0] FIELD_HOUR   = 3'd0;
   localparam logic [2:0] FIELD_MINUTE = 3'd1;
   localparam logic [2:0] FIELD_SECOND = 3'd2;
   localparam logic [2:0] FIELD_DAY    = 3'd3;
   localparam logic [2:0] FIELD_MONTH  = 3'd4;
   localparam logic [2:0] FIELD_YEAR   = 3'd5;
   localparam logic [2:0] FIELD_DONE   = 3'd6;

   localparam logic CSR_YEAR_LOW  = 1'b0;
   localparam logic CSR_YEAR_HIGH = 1'b1;

   localparam logic [5:0] HOUR_MAX        = 6'd23;
   localparam logic [5:0] MINUTE_MAX      = 6'd59;
   localparam logic [5:0] SECOND_MAX      = 6'd59;
   localparam logic [5:0] DAY_MIN         = 6'd1;
   localparam logic [5:0] DAY_MAX         = 6'd31;
   localparam logic [5:0] MONTH_MIN       = 6'd1;
   localparam logic [5:0] MONTH_MAX       = 6'd12;
   localparam logic [5:0] YEAR_LOW_RESET  = 6'd18;
   localparam logic [5:0] YEAR_HIGH_RESET = 6'd50;

   typedef struct packed {
      logic key_right;
      logic key_left;
      logic key_up;
      logic key_down;
   } req_type;

   typedef struct packed {
      logic [2:0] field_select;
      logic [4:0] hour_value;
      logic [5:0] minute_value;
      logic [5:0] second_value;
      logic [4:0] day_value;
      logic [3:0] month_value;
      logic [5:0] year_value;
      logic       commit;
   } rsp_type;

   typedef struct packed {
      logic [5:0] year_low;
      logic [5:0] year_high;
   } cfg_type;

   typedef struct packed {
      logic [2:0] cursor;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [4:0] day;
      logic [3:0] month;
      logic [5:0] year;
   } setting_type;

   // Step v by one inside lo..hi, wrapping at the ends; out of range snaps to lo going up, hi going down.
   function automatic logic [5:0] wrap_step(input logic [5:0] v, input logic [5:0] lo,
                                            input logic [5:0] hi, input logic up);
      logic [5:0] r;
      if (up) begin
         r = (v >= hi || v < lo) ? lo : v + 6'd1;
      end else begin
         r = (v <= lo || v > hi) ? hi : v - 6'd1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/time_date_button_setter.sv -----
// Button-driven time and date entry.
// req channel: one word per poll of the right, left, up and down buttons.
// rsp channel: one word per poll, showing the cursor and all six settings
// after that poll, with commit high on the poll whose right press confirms
// the year. After commit the cursor rests on the finished code and every
// later poll returns the held values with commit low.
// csr channel: index 0 writes year_low, index 1 writes year_high; always
// ready, and meant to be written while no poll is in flight.
// The response to an accepted word is on rsp in the cycle after it is accepted.
// Throughput is one poll per cycle while rsp_ready is high; the single response register is the
// only storage on the path and req_ready follows its occupancy, so the
// block accepts a new poll in the same cycle the held response is taken.
// When rsp_ready is low with a response waiting, req_ready drops and the
// response is held.
// Reset clears the cursor to hours, the settings to 0:00:00, day 1,
// month 1, year 18, the bounds to 18 and 50, and empties the response.
`default_nettype none
`include "assert_macros.svh"
module time_date_button_setter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tdbs_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tdbs_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [5:0]        csr_data
);

   tdbs_pkg::cfg_type     cfg;
   tdbs_pkg::setting_type state_ff;
   tdbs_pkg::setting_type state_in;
   tdbs_pkg::rsp_type     rsp_ff;
   tdbs_pkg::rsp_type     rsp_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  commit;
   logic                  accept;

   tdbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tdbs_update u_update (
      .cur    (state_ff),
      .keys   (req_data),
      .cfg    (cfg),
      .nxt    (state_in),
      .commit (commit)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      rsp_in.field_select = state_in.cursor;
      rsp_in.hour_value   = state_in.hour;
      rsp_in.minute_value = state_in.minute;
      rsp_in.second_value = state_in.second;
      rsp_in.day_value    = state_in.day;
      rsp_in.month_value  = state_in.month;
      rsp_in.year_value   = state_in.year;
      rsp_in.commit       = commit;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cursor <= tdbs_pkg::FIELD_HOUR;
         state_ff.hour   <= 5'd0;
         state_ff.minute <= 6'd0;
         state_ff.second <= 6'd0;
         state_ff.day    <= 5'd1;
         state_ff.month  <= 4'd1;
         state_ff.year   <= tdbs_pkg::YEAR_LOW_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   // payload register: loaded on accept only
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   `ASSERT_IMPLY(a_commit_done, clock, reset, rsp_valid_ff && rsp_ff.commit, rsp_ff.field_select == tdbs_pkg::FIELD_DONE, "commit without finished cursor")
   `ASSERT_NEXT(a_done_sticky, clock, reset, state_ff.cursor == tdbs_pkg::FIELD_DONE, state_ff.cursor == tdbs_pkg::FIELD_DONE, "finished cursor left")
   `ASSERT_NEXT(a_accept_rsp, clock, reset, accept, rsp_valid_ff && rsp_ff.field_select == $past(state_in.cursor), "accepted poll lost its response")

endmodule
`default_nettype wire

// ----- rtl/core/tdbs_csr.sv -----
`default_nettype none
module tdbs_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [5:0]       csr_data,
   output tdbs_pkg::cfg_type     cfg
);

   tdbs_pkg::cfg_type cfg_ff;
   tdbs_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tdbs_pkg::CSR_YEAR_LOW:  cfg_in.year_low  = csr_data;
            tdbs_pkg::CSR_YEAR_HIGH: cfg_in.year_high = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.year_low  <= tdbs_pkg::YEAR_LOW_RESET;
         cfg_ff.year_high <= tdbs_pkg::YEAR_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/tdbs_update.sv -----
`default_nettype none
module tdbs_update (
   input  wire tdbs_pkg::setting_type cur,
   input  wire tdbs_pkg::req_type     keys,
   input  wire tdbs_pkg::cfg_type     cfg,
   output tdbs_pkg::setting_type      nxt,
   output logic                       commit
);

   logic change;
   logic dir_up;

   always_comb begin
      nxt    = cur;
      commit = 1'b0;
      change = 1'b0;
      dir_up = 1'b0;
      if (cur.cursor != tdbs_pkg::FIELD_DONE) begin
         if (keys.key_right) begin
            if (cur.cursor == tdbs_pkg::FIELD_YEAR) begin
               commit     = 1'b1;
               nxt.cursor = tdbs_pkg::FIELD_DONE;
            end else begin
               nxt.cursor = cur.cursor + 3'd1;
            end
         end else if (keys.key_left) begin
            if (cur.cursor != tdbs_pkg::FIELD_HOUR) begin
               nxt.cursor = cur.cursor - 3'd1;
            end
         end else if (keys.key_up || keys.key_down) begin
            change = 1'b1;
            dir_up = keys.key_up;
         end
      end

      if (change) begin
         case (cur.cursor)
            tdbs_pkg::FIELD_HOUR: begin
               nxt.hour = 5'(tdbs_pkg::wrap_step(6'(cur.hour), 6'd0,
                                                 tdbs_pkg::HOUR_MAX, dir_up));
            end
            tdbs_pkg::FIELD_MINUTE: begin
               nxt.minute = tdbs_pkg::wrap_step(cur.minute, 6'd0,
                                                tdbs_pkg::MINUTE_MAX, dir_up);
            end
            tdbs_pkg::FIELD_SECOND: begin
               nxt.second = tdbs_pkg::wrap_step(cur.second, 6'd0,
                                                tdbs_pkg::SECOND_MAX, dir_up);
            end
            tdbs_pkg::FIELD_DAY: begin
               nxt.day = 5'(tdbs_pkg::wrap_step(6'(cur.day), tdbs_pkg::DAY_MIN,
                                                tdbs_pkg::DAY_MAX, dir_up));
            end
            tdbs_pkg::FIELD_MONTH: begin
               nxt.month = 4'(tdbs_pkg::wrap_step(6'(cur.month), tdbs_pkg::MONTH_MIN,
                                                  tdbs_pkg::MONTH_MAX, dir_up));
            end
            tdbs_pkg::FIELD_YEAR: begin
               nxt.year = tdbs_pkg::wrap_step(cur.year, cfg.year_low,
                                              cfg.year_high, dir_up);
            end
            default: nxt = cur;
         endcase
      end
   end

endmodule
`default_nettype wire
